// ===== design/firlh_pkg.sv =====
// Shared types, coefficient tables and helper functions for the FIR filter.
package firlh_pkg;

  localparam int TABLE_SLOTS = 64;
  localparam int IDX_W       = 6;   // addresses TABLE_SLOTS coefficients
  localparam int CNT_W       = 7;   // holds a tap count up to TABLE_SLOTS plus slack
  localparam int TABLE_FRAC  = 15;
  localparam int LP_LEN      = 29;
  localparam int HP_LEN      = 25;
  localparam int COEF_MAX_W  = 26;  // scaled coefficient at the widest fraction setting

  typedef logic signed [15:0] q15_t;

  localparam q15_t LP_COEF [LP_LEN] = '{
    -16'sd287,  -16'sd443,  -16'sd690,  -16'sd924,  -16'sd1078, -16'sd1075,
    -16'sd852,  -16'sd371,   16'sd366,   16'sd1308,  16'sd2358,  16'sd3385,
     16'sd4251,  16'sd4828,  16'sd5031,  16'sd4828,  16'sd4251,  16'sd3385,
     16'sd2358,  16'sd1308,  16'sd366,  -16'sd371,  -16'sd852,  -16'sd1075,
    -16'sd1078, -16'sd924,  -16'sd690,  -16'sd443,  -16'sd287
  };

  localparam q15_t HP_COEF [HP_LEN] = '{
     16'sd1949, -16'sd2709, -16'sd1061,  16'sd71,    16'sd939,   16'sd1477,
     16'sd1453,  16'sd661,  -16'sd908,  -16'sd2992, -16'sd5110, -16'sd6681,
     16'sd25501,
    -16'sd6681, -16'sd5110, -16'sd2992, -16'sd908,   16'sd661,   16'sd1453,
     16'sd1477,  16'sd939,   16'sd71,   -16'sd1061, -16'sd2709,  16'sd1949
  };

  // Sequencer strobes to the datapath.
  typedef struct packed {
    logic shift;   // new sample enters the delay line, accumulator clears
    logic step;    // one tap issued, delay window rotates by one
    logic round;   // accumulator scaled down
    logic load;    // saturated result into the output register
  } firlh_ctl_t;

  // Q1.15 table entry; taps past the end of a table are zero.
  function automatic q15_t coef_q15(logic hp, logic [IDX_W-1:0] idx);
    q15_t c;
    c = '0;
    if (hp) begin
      if (idx < IDX_W'(HP_LEN)) c = HP_COEF[idx[4:0]];
    end else begin
      if (idx < IDX_W'(LP_LEN)) c = LP_COEF[idx[4:0]];
    end
    return c;
  endfunction

  // Move a Q1.15 value to another fraction width; coarser grids round the
  // magnitude half up and keep the sign.
  function automatic logic signed [COEF_MAX_W-1:0] scale_coef(q15_t q, int frac);
    logic signed [COEF_MAX_W-1:0] c;
    logic [COEF_MAX_W-1:0]        mag;
    int                           sh;
    c = COEF_MAX_W'(q);
    if (frac >= TABLE_FRAC) begin
      return c <<< (frac - TABLE_FRAC);
    end
    sh  = TABLE_FRAC - frac;
    mag = (c < 0) ? COEF_MAX_W'(-c) : COEF_MAX_W'(c);
    mag = (mag + (COEF_MAX_W'(1) << (sh - 1))) >> sh;
    return (c < 0) ? -$signed(mag) : $signed(mag);
  endfunction

endpackage

// ===== design/firlh_delay.sv =====
// Sample delay line: shifts on a new sample, rotates its active window while taps are read.
module firlh_delay import firlh_pkg::*; #(
  parameter int TAPS = 29,
  parameter int SW   = 24
) (
  input  logic                 clk,
  input  logic                 rst,
  input  firlh_ctl_t           ctl,
  input  logic [CNT_W-1:0]     taps,
  input  logic signed [SW-1:0] sample_in,
  output logic signed [SW-1:0] tap0
);

  logic signed [SW-1:0] dl [TAPS];

  assign tap0 = dl[0];

  for (genvar g = 0; g < TAPS; g++) begin : g_ent
    logic signed [SW-1:0] dn_val;
    logic signed [SW-1:0] up_val;

    if (g == 0) begin : g_first
      assign dn_val = sample_in;
    end else begin : g_mid
      assign dn_val = dl[g-1];
    end

    if (g == TAPS - 1) begin : g_last
      assign up_val = dl[0];
    end else begin : g_up
      assign up_val = dl[g+1];
    end

    // entries at or past the active length hold their value
    always_ff @(posedge clk) begin
      if (rst) begin
        dl[g] <= '0;
      end else if (ctl.shift && (CNT_W'(g) < taps)) begin
        dl[g] <= dn_val;
      end else if (ctl.step && (CNT_W'(g) == taps - CNT_W'(1))) begin
        dl[g] <= dl[0];
      end else if (ctl.step && (CNT_W'(g) < taps)) begin
        dl[g] <= up_val;
      end
    end
  end

endmodule

// ===== design/firlh_mac.sv =====
// Shared multiply-accumulate datapath with coefficient lookup, scaling and saturation.
module firlh_mac import firlh_pkg::*; #(
  parameter int SW   = 24,
  parameter int FRAC = 15
) (
  input  logic                 clk,
  input  logic                 rst,
  input  firlh_ctl_t           ctl,
  input  logic                 hp,
  input  logic [IDX_W-1:0]     coef_idx,
  input  logic signed [SW-1:0] tap0,
  output logic signed [SW-1:0] sample_out
);

  localparam int CW = FRAC + 2;
  localparam int PW = SW + CW;
  localparam int AW = PW + IDX_W;
  localparam int YW = AW - FRAC;
  localparam logic signed [AW-1:0] BIAS = {{(AW-FRAC){1'b0}}, {FRAC{1'b1}}};

  logic signed [SW-1:0] tap_r;
  logic signed [CW-1:0] coef_r;
  logic signed [PW-1:0] prod;
  logic signed [AW-1:0] acc;
  logic signed [AW-1:0] rnd;
  logic signed [YW-1:0] y_r;
  logic                 v1;
  logic                 v2;
  logic                 fits;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= ctl.step;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.step) begin
      tap_r  <= tap0;
      coef_r <= CW'(scale_coef(coef_q15(hp, coef_idx), FRAC));
    end
    if (v1) prod <= tap_r * coef_r;
    if (ctl.shift) begin
      acc <= '0;
    end else if (v2) begin
      acc <= acc + AW'(prod);
    end
  end

  // truncate toward zero: bias negative sums before the arithmetic shift
  assign rnd  = acc + (acc[AW-1] ? BIAS : '0);
  assign fits = (&y_r[YW-1:SW-1]) | ~(|y_r[YW-1:SW-1]);

  always_ff @(posedge clk) begin
    if (ctl.round) y_r <= YW'(rnd >>> FRAC);
    if (ctl.load) begin
      sample_out <= fits ? y_r[SW-1:0] : {y_r[YW-1], {(SW-1){~y_r[YW-1]}}};
    end
  end

endmodule

// ===== design/firlh_ctrl.sv =====
// Sequencer: input handshake, tap counter and output valid.
module firlh_ctrl import firlh_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  logic [CNT_W-1:0]   taps,
  output firlh_ctl_t         ctl,
  output logic [IDX_W-1:0]   coef_idx
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_MAC   = 4'b0010,
    ST_ROUND = 4'b0100,
    ST_SAT   = 4'b1000
  } firlh_state_t;

  firlh_state_t     state, state_next;
  logic [CNT_W-1:0] cnt;
  logic             out_free;

  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;
  assign coef_idx = cnt[IDX_W-1:0];

  always_comb begin
    state_next = state;
    ctl        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          ctl.shift  = 1'b1;
          state_next = ST_MAC;
        end
      end
      ST_MAC: begin
        ctl.step = (cnt < taps);
        // the counter runs on past the last tap to drain the multiply and accumulate stages
        if (cnt == taps + CNT_W'(1)) state_next = ST_ROUND;
      end
      ST_ROUND: begin
        ctl.round  = 1'b1;
        state_next = ST_SAT;
      end
      ST_SAT: begin
        if (out_free) begin
          ctl.load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.shift) begin
        cnt <= '0;
      end else if (state == ST_MAC) begin
        cnt <= cnt + CNT_W'(1);
      end
      if (ctl.load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== design/fir_filter_lp_hp_unit.sv =====
// Top level of the low-pass / high-pass FIR filter.
//
// Usage:
//   Input channel (in_valid/in_ready, sample_in): one signed sample per
//   transaction. Output channel (out_valid/out_ready, sample_out): one
//   filtered sample per input, in order. Config channel (cfg_valid/cfg_ready,
//   cfg_data): cfg_data = 0 selects the MAX_TAPS low-pass filter, 1 the
//   high-pass filter; cfg_ready is always high. Write it only while idle.
//   One multiplier is shared over all taps: after an input transaction the
//   block issues the taps and drains the multiply and accumulate stages,
//   scales the sum, then saturates it into the output register. in_ready
//   rises with the result, so the block takes no new sample before it is
//   through with the last one.
//   The output register parts the channels: a new sample is taken while a
//   result still waits; a stalled receiver holds the block only once the
//   next result is ready to load.
//   Reset clears the delay line and selects low-pass; no clearing pass.
//   A mode change does not clear the delay line.
module fir_filter_lp_hp_unit import firlh_pkg::*; #(
  parameter int MAX_TAPS       = 29,
  parameter int HP_TAPS        = 25,
  parameter int SAMPLE_WIDTH   = 24,
  parameter int COEF_FRAC_BITS = 15
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [SAMPLE_WIDTH-1:0] sample_out,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic                           cfg_data
);

  localparam int HP_ACTIVE = (HP_TAPS < MAX_TAPS) ? HP_TAPS : MAX_TAPS;

  logic                           filter_select;
  logic [CNT_W-1:0]               taps;
  firlh_ctl_t                     ctl;
  logic [IDX_W-1:0]               coef_idx;
  logic signed [SAMPLE_WIDTH-1:0] tap0;

  assign cfg_ready = 1'b1;
  assign taps      = filter_select ? CNT_W'(HP_ACTIVE) : CNT_W'(MAX_TAPS);

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_select <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      filter_select <= cfg_data;
    end
  end

  firlh_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .taps      (taps),
    .ctl       (ctl),
    .coef_idx  (coef_idx)
  );

  firlh_delay #(
    .TAPS (MAX_TAPS),
    .SW   (SAMPLE_WIDTH)
  ) u_delay (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .taps      (taps),
    .sample_in (sample_in),
    .tap0      (tap0)
  );

  firlh_mac #(
    .SW   (SAMPLE_WIDTH),
    .FRAC (COEF_FRAC_BITS)
  ) u_mac (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .hp         (filter_select),
    .coef_idx   (coef_idx),
    .tap0       (tap0),
    .sample_out (sample_out)
  );

endmodule

// ===== design/firlh_checker.sv =====
// Port-level checks for the FIR filter, bound to the top level.
module firlh_checker #(
  parameter int SAMPLE_WIDTH = 24
) (
  input logic                    clk,
  input logic                    rst,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [SAMPLE_WIDTH-1:0] sample_out
);

  // a sample keeps the block busy for at least the tap pipeline
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready ##1 !in_ready)
    else $error("in_ready came back too early after an input transaction");

  // finishing an item always leaves a result on the output
  a_done_has_result: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $rose(in_ready) |-> out_valid)
    else $error("block went idle without presenting a result");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(sample_out))
    else $error("stalled result changed or dropped");

  a_reset_state: assert property (@(posedge clk)
    rst |=> in_ready && !out_valid)
    else $error("block not idle and empty after reset");

endmodule

bind fir_filter_lp_hp_unit firlh_checker #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_firlh_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .sample_out (sample_out)
);

// ===== dv/fir_filter_lp_hp_checker.sv =====
// Scoreboard for the FIR filter: tracks the band select and delay line, checks every output.
`timescale 1ns / 1ps
module fir_filter_lp_hp_checker #(
  parameter int SW = 24
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic signed [SW-1:0] sample_in,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic signed [SW-1:0] sample_out,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic                 cfg_data,
  output int                   fail_count,
  output int                   outstanding,
  output int                   lp_checked,
  output int                   hp_checked,
  output int                   clipped
);

  localparam int     LP_LEN = 29;
  localparam int     HP_LEN = 25;
  localparam int     FRAC   = 15;
  localparam longint SMAX   = (longint'(1) << (SW - 1)) - 1;
  localparam longint SMIN   = -SMAX - 1;

  // Q1.15 taps, index 0 multiplies the newest sample
  localparam int LP_TAB [LP_LEN] = '{
    -287, -443, -690, -924, -1078, -1075, -852, -371, 366, 1308,
    2358, 3385, 4251, 4828, 5031, 4828, 4251, 3385, 2358, 1308,
    366, -371, -852, -1075, -1078, -924, -690, -443, -287
  };
  localparam int HP_TAB [HP_LEN] = '{
    1949, -2709, -1061, 71, 939, 1477, 1453, 661, -908, -2992,
    -5110, -6681, 25501, -6681, -5110, -2992, -908, 661, 1453, 1477,
    939, 71, -1061, -2709, 1949
  };

  typedef logic signed [SW-1:0] sample_t;

  typedef struct {
    sample_t value;
    logic    hp;
    logic    sat;
  } filtered_t;

  filtered_t expected_q [$];
  filtered_t head;
  longint    history [LP_LEN];
  logic      hp_sel;
  int        n_err, n_lp, n_hp, n_sat, n_seen;

  task automatic report_mismatch(input string msg);
    n_err++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // Shifts only the taps of the selected band; entries past them stay stale.
  function automatic filtered_t filter_sample(input sample_t x);
    filtered_t r;
    longint    acc, mag;
    logic      neg;
    int        n, i;
    n = hp_sel ? HP_LEN : LP_LEN;
    for (i = n - 1; i > 0; i--) history[i] = history[i - 1];
    history[0] = longint'(x);
    acc = 0;
    for (i = 0; i < n; i++) begin
      if (hp_sel) acc += history[i] * HP_TAB[i];
      else acc += history[i] * LP_TAB[i];
    end
    // truncate toward zero, then clip to the sample range
    neg = acc < 0;
    mag = neg ? -acc : acc;
    mag = mag >> FRAC;
    acc = neg ? -mag : mag;
    r.sat = 1'b0;
    if (acc > SMAX) begin
      acc   = SMAX;
      r.sat = 1'b1;
    end else if (acc < SMIN) begin
      acc   = SMIN;
      r.sat = 1'b1;
    end
    r.value = sample_t'(acc);
    r.hp    = hp_sel;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      expected_q.delete();
      hp_sel = 1'b0;
      foreach (history[i]) history[i] = 0;
    end else begin
      if (cfg_valid && cfg_ready) hp_sel = cfg_data;
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("output %0d = %0d with no sample pending",
                                    n_seen, sample_out));
        end else begin
          head = expected_q.pop_front();
          if (sample_out !== head.value)
            report_mismatch($sformatf("output %0d (%s): expected %0d, got %0d", n_seen,
                                      head.hp ? "high-pass" : "low-pass",
                                      head.value, sample_out));
          if (head.hp) n_hp++;
          else n_lp++;
          if (head.sat) n_sat++;
        end
        n_seen++;
      end
      if (in_valid && in_ready) expected_q.push_back(filter_sample(sample_in));
    end
    fail_count  <= n_err;
    outstanding <= expected_q.size();
    lp_checked  <= n_lp;
    hp_checked  <= n_hp;
    clipped     <= n_sat;
  end

endmodule

// ===== dv/fir_filter_lp_hp_unit_test.sv =====
// Testbench top: directed and random sample streams into the FIR filter, verdict at the end.
`timescale 1ns / 1ps
module fir_filter_lp_hp_unit_test;

  localparam int   SW            = 24;
  localparam logic SEL_LOWPASS   = 1'b0;
  localparam logic SEL_HIGHPASS  = 1'b1;
  localparam int   LP_LEN        = 29;
  localparam int   HP_LEN        = 25;
  // bit i set where tap i has a negative coefficient
  localparam logic [LP_LEN-1:0] LP_NEG = 29'h1FE000FF;
  localparam logic [HP_LEN-1:0] HP_NEG = 25'h0C1EF06;
  localparam logic signed [SW-1:0] SMAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] SMIN = {1'b1, {(SW-1){1'b0}}};
  localparam int   ITEMS_PER_SEG = 41;
  localparam int   HOLD_CYCLES   = 300;
  localparam int   SETTLE_CYCLES = 40;
  localparam int   CYCLE_LIMIT   = 400000;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  logic signed [SW-1:0] sample_in;
  logic                 out_valid;
  logic                 out_ready;
  logic signed [SW-1:0] sample_out;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic                 cfg_data;

  int   fail_count, outstanding, lp_checked, hp_checked, clipped;
  int   tx_idle_pct, rx_idle_pct, items_sent, cycles;
  logic cur_sel;
  logic stall_req, stall_done;

  fir_filter_lp_hp_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .sample_in (sample_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sample_out(sample_out),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  fir_filter_lp_hp_checker #(.SW(SW)) u_check (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .sample_in  (sample_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sample_out (sample_out),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .outstanding(outstanding),
    .lp_checked (lp_checked),
    .hp_checked (hp_checked),
    .clipped    (clipped)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycles, outstanding);
    $display("FAIL fir_filter_lp_hp_unit");
    $finish;
  end

  // Output side: random back-pressure, plus one long hold-off on request.
  initial begin
    out_ready  <= 1'b0;
    stall_done <= 1'b0;
    forever begin
      if (stall_req && !stall_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        stall_done <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
      @(posedge clk);
    end
  end

  // Returns with the transaction taken at the current edge; valid stays up.
  task automatic send_sample(input logic signed [SW-1:0] v);
    if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < tx_idle_pct) @(posedge clk);
    end
    in_valid  <= 1'b1;
    sample_in <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic select_band(input logic sel);
    drain;
    cfg_valid <= 1'b1;
    cfg_data  <= sel;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cur_sel = sel;
  endtask

  // Sample m of a window whose signs match the taps, so the sum heads for full scale.
  function automatic logic signed [SW-1:0] window_value(input int m, input logic flip,
                                                        input logic full);
    logic neg;
    int   mag;
    neg = ((cur_sel == SEL_HIGHPASS) ? HP_NEG[m] : LP_NEG[m]) ^ flip;
    mag = full ? int'(SMAX) : int'($urandom_range(int'(SMAX), 6291456));
    return neg ? SW'(-mag - 1) : SW'(mag);
  endfunction

  task automatic send_random(input int count);
    int   sent, kind, len, m, small_v;
    logic flip, full;
    sent = 0;
    while (sent < count) begin
      kind = $urandom_range(99);
      if (kind < 4) begin
        len = (cur_sel == SEL_HIGHPASS) ? HP_LEN : LP_LEN;
        if ($urandom_range(3) == 0) len = $urandom_range(len - 1, 2);  // cut short
        flip = 1'($urandom_range(1));
        for (m = 0; m < len; m++) begin
          full = ($urandom_range(3) == 0);
          send_sample(window_value(m, flip, full));
        end
        sent += len;
      end else if (kind < 20) begin
        case ($urandom_range(4))
          0:       send_sample(SMAX);
          1:       send_sample(SMIN);
          2:       send_sample('0);
          3:       send_sample(SW'(1));
          default: send_sample(SW'(-1));
        endcase
        sent++;
      end else if (kind < 40) begin
        small_v = int'($urandom_range(511)) - 256;
        send_sample(SW'(small_v));
        sent++;
      end else begin
        send_sample(SW'($urandom()));
        sent++;
      end
    end
  endtask

  initial begin
    int ph, seg, m;
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    sample_in   <= '0;
    cfg_valid   <= 1'b0;
    cfg_data    <= SEL_LOWPASS;
    stall_req   <= 1'b0;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    items_sent  = 0;
    cur_sel     = SEL_LOWPASS;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes in low-pass, a full-scale high-pass window that clips,
    // then back to low-pass with stale taps left over from the high-pass run
    send_sample(SMAX);
    send_sample(SMIN);
    send_sample(SW'(-1));
    select_band(SEL_HIGHPASS);
    for (m = 0; m < HP_LEN; m++) send_sample(window_value(m, 1'b0, 1'b1));
    select_band(SEL_LOWPASS);
    send_sample(SW'(1));
    send_sample('0);

    for (ph = 0; ph < 3; ph++) begin
      tx_idle_pct = (ph == 0) ? 21 : (ph == 1) ? 84 : 0;
      rx_idle_pct = (ph == 0) ? 84 : (ph == 1) ? 21 : 0;
      for (seg = 0; seg < 3; seg++) begin
        select_band((seg[0] ^ ph[0]) ? SEL_HIGHPASS : SEL_LOWPASS);
        if (ph == 0 && seg == 1) stall_req <= 1'b1;
        send_random(ITEMS_PER_SEG);
      end
    end

    drain;
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d samples: %0d low-pass and %0d high-pass results checked,",
             items_sent, lp_checked, hp_checked);
    $display("%0d of them clipped; band switched over stale taps, one long output stall",
             clipped);
    if (fail_count == 0) begin
      $display("PASS fir_filter_lp_hp_unit");
    end else begin
      $display("FAIL fir_filter_lp_hp_unit");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/firlh_pkg.sv
design/firlh_delay.sv
design/firlh_mac.sv
design/firlh_ctrl.sv
design/fir_filter_lp_hp_unit.sv
design/firlh_checker.sv
dv/fir_filter_lp_hp_checker.sv
dv/fir_filter_lp_hp_unit_test.sv
